// File: hdl/tspm_pkg.sv
// Shared types and constants for the triple store pattern match unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package tspm_pkg;
    localparam int TripleDepth = 256;
    localparam int NodeDepth   = 256;
    localparam int TIdxW = $clog2(TripleDepth);
    localparam int NIdxW = $clog2(NodeDepth);
    localparam int TCntW = $clog2(TripleDepth + 1);
    localparam int NCntW = $clog2(NodeDepth + 1);
    localparam int IdW   = 64;
    localparam int LimW  = 9;
    localparam int ResW  = 6;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_EXACT  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_COUNT  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRIP_FULL = 2'd1;
    localparam logic [1:0] ST_NODE_FULL = 2'd2;

    localparam logic [1:0] REG_TRIPLE = 2'd0;
    localparam logic [1:0] REG_NODE   = 2'd1;
    localparam logic [1:0] REG_RESULT = 2'd2;

    localparam logic [IdW-1:0] Wildcard = '1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture the input word, clear scan state
        logic tscan;      // triple store scan step
        logic nscan;      // node table scan step
        logic nsel_obj;   // node scan looks for the object
        logic node_write; // append the looked-up node
        logic trip_write; // append the triple
        logic emit_match; // present the current triple as a match word
        logic emit_close; // present the closing word
        logic [1:0] status;
    } tspm_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [1:0] op;
        logic tdone;      // triple scan index reached the count
        logic ndone;      // node scan index reached the count
        logic hit;        // compare result of the last registered read
        logic hit_valid;  // hit belongs to a real entry
        logic trip_full;
        logic node_full;
        logic res_full;   // kept matches reached result_limit
        logic out_busy;   // output register holds an untaken word
    } tspm_stat_t;
endpackage
`default_nettype wire

// File: hdl/tspm_datapath.sv
// Datapath: triple and node memories, scan counters, compares, output register.
// Depends on tspm_pkg.
`default_nettype none
module tspm_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire tspm_pkg::tspm_cmd_t cmd,
    output tspm_pkg::tspm_stat_t stat,
    input  wire logic [193:0] in_word,
    input  wire logic [8:0] triple_limit,
    input  wire logic [8:0] node_limit,
    input  wire logic [5:0] result_limit,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [207:0] out_data,
    output logic out_last
);
    import tspm_pkg::*;

    logic [IdW-1:0] sub_mem [TripleDepth];
    logic [IdW-1:0] pred_mem [TripleDepth];
    logic [IdW-1:0] obj_mem [TripleDepth];
    logic [IdW-1:0] node_mem [NodeDepth];

    logic [1:0] op_reg;
    logic [IdW-1:0] s_reg, p_reg, o_reg;
    logic [TCntW-1:0] triples_reg, tidx_reg;
    logic [NCntW-1:0] nodes_reg, nidx_reg;
    logic [IdW-1:0] rs_reg, rp_reg, ro_reg, rn_reg;
    logic rvalid_reg, nvalid_reg;
    logic [TCntW-1:0] cnt_reg;
    logic trunc_reg, found_reg;
    logic out_valid_reg, out_last_reg;
    logic [207:0] out_data_reg;
    logic [IdW-1:0] nkey;

    assign nkey = cmd.nsel_obj ? o_reg : s_reg;

    // Memories: synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.trip_write)
        begin
            sub_mem[triples_reg[TIdxW-1:0]]  <= s_reg;
            pred_mem[triples_reg[TIdxW-1:0]] <= p_reg;
            obj_mem[triples_reg[TIdxW-1:0]]  <= o_reg;
        end
        rs_reg <= sub_mem[tidx_reg[TIdxW-1:0]];
        rp_reg <= pred_mem[tidx_reg[TIdxW-1:0]];
        ro_reg <= obj_mem[tidx_reg[TIdxW-1:0]];
        if (cmd.node_write)
            node_mem[nodes_reg[NIdxW-1:0]] <= nkey;
        rn_reg <= node_mem[nidx_reg[NIdxW-1:0]];
        if (cmd.load)
        begin
            op_reg <= in_word[1:0];
            s_reg  <= in_word[65:2];
            p_reg  <= in_word[129:66];
            o_reg  <= in_word[193:130];
        end
    end

    logic thit, shit, nhit;
    always_comb
    begin
        shit = (rs_reg == s_reg);
        case (op_reg)
            OP_EXACT: thit = shit && rp_reg == p_reg && ro_reg == o_reg;
            OP_QUERY: thit = (s_reg == Wildcard || shit)
                          && (p_reg == Wildcard || rp_reg == p_reg)
                          && (o_reg == Wildcard || ro_reg == o_reg);
            OP_COUNT: thit = shit;
            default:  thit = 1'b0;
        endcase
        nhit = (rn_reg == nkey);
    end

    logic [8:0] tlim, nlim;
    assign tlim = (triple_limit > 9'(TripleDepth)) ? 9'(TripleDepth) : triple_limit;
    assign nlim = (node_limit > 9'(NodeDepth)) ? 9'(NodeDepth) : node_limit;

    always_comb
    begin
        stat.op = op_reg;
        stat.tdone = (tidx_reg == triples_reg);
        stat.ndone = (nidx_reg == nodes_reg);
        stat.hit = rvalid_reg ? thit : (nvalid_reg && nhit);
        stat.hit_valid = rvalid_reg || nvalid_reg;
        stat.trip_full = (9'(triples_reg) >= tlim);
        stat.node_full = (9'(nodes_reg) >= nlim);
        stat.res_full = (cnt_reg >= TCntW'(result_limit));
        stat.out_busy = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            triples_reg <= '0;
            nodes_reg <= '0;
            tidx_reg <= '0;
            nidx_reg <= '0;
            rvalid_reg <= 1'b0;
            nvalid_reg <= 1'b0;
            cnt_reg <= '0;
            trunc_reg <= 1'b0;
            found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            rvalid_reg <= cmd.tscan && !stat.tdone;
            nvalid_reg <= cmd.nscan && !stat.ndone;
            if (cmd.tscan && !stat.tdone)
                tidx_reg <= tidx_reg + 1'b1;
            if (cmd.nscan && !stat.ndone)
                nidx_reg <= nidx_reg + 1'b1;
            if (cmd.load)
            begin
                tidx_reg <= '0;
                nidx_reg <= '0;
                cnt_reg <= '0;
                trunc_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            // The node scan restarts from the first entry whenever it pauses.
            if (!cmd.nscan && !cmd.load)
                nidx_reg <= '0;
            // A tally, a found flag or a truncation is recorded as compares come back.
            if (rvalid_reg && thit && !cmd.emit_match)
            begin
                if (op_reg == OP_COUNT)
                    cnt_reg <= cnt_reg + 1'b1;
                else if (op_reg == OP_EXACT)
                    found_reg <= 1'b1;
                else if (stat.res_full)
                    trunc_reg <= 1'b1;
            end
            if (cmd.node_write)
                nodes_reg <= nodes_reg + 1'b1;
            if (cmd.trip_write)
                triples_reg <= triples_reg + 1'b1;
            if (cmd.emit_match)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                out_valid_reg <= 1'b1;
                out_last_reg <= 1'b0;
                out_data_reg <= {13'd0, ro_reg, rp_reg, rs_reg, 1'b0, 2'd0};
            end
            if (cmd.emit_close)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg <= 1'b1;
                out_data_reg <= {3'd0, trunc_reg, 9'(cnt_reg), 192'd0,
                                 found_reg, cmd.status};
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;
endmodule
`default_nettype wire

// File: hdl/tspm_ctrl.sv
// Controller state machine sequencing scans, inserts and result words.
// Depends on tspm_pkg.
`default_nettype none
module tspm_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire tspm_pkg::tspm_stat_t stat,
    output tspm_pkg::tspm_cmd_t cmd
);
    import tspm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_TSCAN, S_NSCAN_S, S_NADD_S, S_NSCAN_O, S_NADD_O,
        S_STORE, S_CLOSE, S_MATCH
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] status_reg, status_next;

    assign in_ready = (state_reg == S_IDLE);

    // Scans stop once a compare returns a hit for the node and exact passes.
    always_comb
    begin
        state_next = state_reg;
        status_next = status_reg;
        cmd = '0;
        cmd.status = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    status_next = ST_OK;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.op == OP_INSERT)
                begin
                    if (stat.trip_full)
                    begin
                        status_next = ST_TRIP_FULL;
                        state_next = S_CLOSE;
                    end
                    else
                        state_next = S_NSCAN_S;
                end
                else
                    state_next = S_TSCAN;
            end
            S_TSCAN:
            begin
                if (stat.hit_valid && stat.hit && stat.op == OP_QUERY
                    && !stat.res_full)
                begin
                    // hold the scan while the match word is handed over
                    if (!stat.out_busy)
                    begin
                        cmd.emit_match = 1'b1;
                        state_next = S_MATCH;
                    end
                end
                else if (stat.hit_valid && stat.hit && stat.op == OP_EXACT)
                    state_next = S_CLOSE;
                else if (stat.tdone && !stat.hit_valid)
                    state_next = S_CLOSE;
                else if (!stat.out_busy)
                    cmd.tscan = 1'b1;
            end
            S_MATCH:
                state_next = S_TSCAN;
            S_NSCAN_S:
            begin
                cmd.nscan = 1'b1;
                if (stat.hit_valid && stat.hit)
                begin
                    cmd.nscan = 1'b0;
                    state_next = S_NSCAN_O;
                end
                else if (stat.ndone && !stat.hit_valid)
                begin
                    cmd.nscan = 1'b0;
                    state_next = S_NADD_S;
                end
            end
            S_NADD_S:
            begin
                if (stat.node_full)
                begin
                    status_next = ST_NODE_FULL;
                    state_next = S_CLOSE;
                end
                else
                begin
                    cmd.node_write = 1'b1;
                    state_next = S_NSCAN_O;
                end
            end
            S_NSCAN_O:
            begin
                cmd.nsel_obj = 1'b1;
                cmd.nscan = 1'b1;
                if (stat.hit_valid && stat.hit)
                begin
                    cmd.nscan = 1'b0;
                    state_next = S_STORE;
                end
                else if (stat.ndone && !stat.hit_valid)
                begin
                    cmd.nscan = 1'b0;
                    state_next = S_NADD_O;
                end
            end
            S_NADD_O:
            begin
                cmd.nsel_obj = 1'b1;
                if (stat.node_full)
                begin
                    status_next = ST_NODE_FULL;
                    state_next = S_CLOSE;
                end
                else
                begin
                    cmd.node_write = 1'b1;
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.trip_write = 1'b1;
                state_next = S_CLOSE;
            end
            S_CLOSE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_close = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
        end
    end
endmodule
`default_nettype wire

// File: hdl/triple_store_pattern_match_unit.sv
// Top level of the triple store pattern match unit: APB registers and streams.
// Depends on tspm_pkg, tspm_ctrl and tspm_datapath.
`default_nettype none
// One operation is taken at a time. Insert scans the node table for the subject
// and the object; exact test, query and outgoing count scan the triple store.
// Scans read one entry per cycle while the output side does not stall; an insert
// makes two node table scans, and a query hands over each match word before it
// scans on. No clearing pass is needed after reset.
module triple_store_pattern_match_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic psel,
    input  wire logic penable,
    input  wire logic pwrite,
    input  wire logic [3:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  wire logic s_axis_tvalid,
    output logic s_axis_tready,
    // op[1:0], subject_id[65:2], predicate_id[129:66], object_id[193:130], zero pad
    input  wire logic [199:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    // status[1:0], found[2], match_subject[66:3], match_predicate[130:67],
    // match_object[194:131], count[203:195], truncated[204], zero pad
    output logic [207:0] m_axis_tdata,
    output logic m_axis_tlast
);
    import tspm_pkg::*;

    logic [8:0] triple_limit_reg, node_limit_reg;
    logic [5:0] result_limit_reg;
    tspm_cmd_t cmd;
    tspm_stat_t stat;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            triple_limit_reg <= 9'd256;
            node_limit_reg <= 9'd256;
            result_limit_reg <= 6'd63;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_TRIPLE: triple_limit_reg <= pwdata[8:0];
                REG_NODE:   node_limit_reg <= pwdata[8:0];
                REG_RESULT: result_limit_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TRIPLE: prdata = {23'd0, triple_limit_reg};
            REG_NODE:   prdata = {23'd0, node_limit_reg};
            REG_RESULT: prdata = {26'd0, result_limit_reg};
            default:    prdata = '0;
        endcase
    end

    tspm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .stat(stat), .cmd(cmd)
    );

    tspm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_word(s_axis_tdata[193:0]), .triple_limit(triple_limit_reg),
        .node_limit(node_limit_reg), .result_limit(result_limit_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_last(m_axis_tlast)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_match && cmd.emit_close))
        else $error("match and closing word issued together");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_match || cmd.emit_close) |-> !stat.out_busy)
        else $error("output word overwritten");
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.trip_write |-> !cmd.node_write && !cmd.load)
        else $error("triple append clashes with other command");
endmodule
`default_nettype wire
